@@ src/sync_framed_lrc_deframer_macros.svh @@
// -----------------------------------------------------------------------------
// sync_framed_lrc_deframer_macros
// Assertion macros shared by the deframer modules.
// -----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_LRC_DEFRAMER_MACROS_SVH
`define SYNC_FRAMED_LRC_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFLD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfld: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SFLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfld: next-cycle check failed");

`endif

@@ src/sfld_pkg.sv @@
// -----------------------------------------------------------------------------
// sfld_pkg
// Types and constants of the framed LRC deframer.
// -----------------------------------------------------------------------------
package sfld_pkg;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 7;
   localparam int STATUS_W  = 3;
   localparam int SKIND_W   = 2;
   localparam int CHAN_W    = 3;
   localparam int CSR_IDX_W = 8;

   localparam int QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MARK_FIRST  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MARK_SECOND = 8'd1;

   // Register reset values
   localparam logic [BYTE_W-1:0] MARK_FIRST_RST  = 8'd65;
   localparam logic [BYTE_W-1:0] MARK_SECOND_RST = 8'd122;

   // Frame size bytes
   localparam logic [BYTE_W-1:0] SIZE_ULTRA = 8'd5;
   localparam logic [BYTE_W-1:0] SIZE_PROP  = 8'd9;
   localparam logic [BYTE_W-1:0] SIZE_IMU   = 8'd19;
   localparam logic [BYTE_W-1:0] SIZE_GPS   = 8'd21;

   localparam logic [BYTE_W-1:0] CHANNELS     = 8'd7;
   localparam logic [BYTE_W-1:0] CHANNEL_BASE = 8'd2;

   // Result kinds
   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // Frame status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL = 3'd4;

   // Sensor kinds
   localparam logic [SKIND_W-1:0] SK_ULTRA = 2'd0;
   localparam logic [SKIND_W-1:0] SK_PROP  = 2'd1;
   localparam logic [SKIND_W-1:0] SK_IMU   = 2'd2;
   localparam logic [SKIND_W-1:0] SK_GPS   = 2'd3;

   // Mark hunting phase
   typedef enum logic [1:0] {
      PH_HUNT      = 2'd0,
      PH_MARK2     = 2'd1,
      PH_BODY      = 2'd2,
      PH_BODY_MARK = 2'd3
   } phase_type;

   // Work queued from the front to the back
   typedef enum logic [1:0] {
      OP_BYTE1   = 2'd0,
      OP_BYTE2   = 2'd1,
      OP_VERDICT = 2'd2
   } op_type;

   // Frame snapshot taken at the closing mark
   typedef struct packed {
      logic              overflowed;
      logic              empty;
      logic              short_body;
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] last;
      logic [BYTE_W-1:0] size;
      logic [BYTE_W-1:0] addr;
   } verdict_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] byte_a;
      logic [BYTE_W-1:0] byte_b;
      logic [POS_W-1:0]  pos;
      verdict_type       verdict;
   } cmd_type;

   // Queue status and handshake between the parts
   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   // One result item
   typedef struct packed {
      logic                item_kind;
      logic [BYTE_W-1:0]   body_byte;
      logic [POS_W-1:0]    byte_position;
      logic [STATUS_W-1:0] frame_status;
      logic [SKIND_W-1:0]  sensor_kind;
      logic [CHAN_W-1:0]   sensor_channel;
      logic                last_of_run;
   } result_type;

endpackage

@@ src/sfld_if.sv @@
// -----------------------------------------------------------------------------
// sfld_if
// Valid/ready channels of the deframer: received bytes, results, registers.
// -----------------------------------------------------------------------------
interface sfld_req_if import sfld_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfld_rsp_if import sfld_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                item_kind;
   logic [BYTE_W-1:0]   body_byte;
   logic [POS_W-1:0]    byte_position;
   logic [STATUS_W-1:0] frame_status;
   logic [SKIND_W-1:0]  sensor_kind;
   logic [CHAN_W-1:0]   sensor_channel;
   logic                last_of_run;

   modport source (output valid, output item_kind, output body_byte,
                   output byte_position, output frame_status, output sensor_kind,
                   output sensor_channel, output last_of_run, input ready);
   modport sink   (input valid, input item_kind, input body_byte,
                   input byte_position, input frame_status, input sensor_kind,
                   input sensor_channel, input last_of_run, output ready);
endinterface

interface sfld_csr_if import sfld_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [BYTE_W-1:0]    wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ src/sync_framed_lrc_deframer.sv @@
// -----------------------------------------------------------------------------
// sync_framed_lrc_deframer
// Byte-stuffed frame deframer with LRC check and sensor classification.
// -----------------------------------------------------------------------------
// req_ch carries one received byte per request. rsp_ch returns the results:
// each stored body byte as it is stored, and a verdict (status, sensor kind,
// ultrasonic channel) when the closing mark arrives. last_of_run marks the
// final result caused by one request; a request yields zero, one or two.
// csr_ch writes the two mark bytes (index 0 first, index 1 second); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this.
// Pipeline: two register stages, a queue slot and then the output register.
// Throughput: one request per cycle while the queue has room. The output
// register delivers one result per cycle while rsp_ch.ready is high, so a
// lone mark byte inside the body (two results) holds back the output side
// while its second byte goes out; a four-entry queue between the front and
// the back absorbs these, and req_ch.ready drops only while that queue is
// full. When rsp_ch.ready is low the result holds, the queue fills and then
// req_ch.ready goes low; nothing is lost.
// Reset: synchronous, active high. Marks return to 65 and 122, the block
// hunts for the opening mark, and the queue and output register empty.
// -----------------------------------------------------------------------------
module sync_framed_lrc_deframer import sfld_pkg::*; #(
   parameter int MAX_BODY = 128
) (
   input  logic        clock,
   input  logic        reset,
   sfld_req_if.sink    req_ch,
   sfld_rsp_if.source  rsp_ch,
   sfld_csr_if.sink    csr_ch
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head;

   // Hunt marks and track the frame
   sfld_front #(
      .MAX_BODY (MAX_BODY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .csr      (csr_ch),
      .q_status (q_status),
      .push     (push),
      .cmd      (push_cmd)
   );

   // Decouple the two sides
   sfld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .status   (q_status),
      .head     (head)
   );

   // Emit results
   sfld_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp      (rsp_ch)
   );

endmodule

@@ src/sfld_front.sv @@
// -----------------------------------------------------------------------------
// sfld_front
// Mark hunting and frame bookkeeping; queues body bytes and verdicts.
// -----------------------------------------------------------------------------
`include "sync_framed_lrc_deframer_macros.svh"

module sfld_front import sfld_pkg::*; #(
   parameter int MAX_BODY = 128
) (
   input  logic             clock,
   input  logic             reset,
   sfld_req_if.sink         req,
   sfld_csr_if.sink         csr,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          cmd
);

   localparam int CW = $clog2(MAX_BODY + 1);

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] mark1_ff, mark2_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] last_ff, last_in;
   logic [BYTE_W-1:0] size_ff, size_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic              ovf_ff, ovf_in;
   logic              accept;
   logic              room1, room2;
   logic [BYTE_W-1:0] rx;
   logic              body_mark_take;

   // Take a request whenever the queue has a free slot
   assign req.ready = !q_status.full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign rx        = req.rx_byte;
   assign room1     = count_ff < CW'(MAX_BODY);
   assign room2     = count_ff < CW'(MAX_BODY - 1);

   assign body_mark_take = accept && (phase_ff == PH_BODY_MARK);

   // Mark registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mark1_ff <= MARK_FIRST_RST;
         mark2_ff <= MARK_SECOND_RST;
      end else if (csr.valid && csr.ready) begin
         if (csr.reg_index == REG_MARK_FIRST) begin
            mark1_ff <= csr.wdata;
         end
         if (csr.reg_index == REG_MARK_SECOND) begin
            mark2_ff <= csr.wdata;
         end
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx == mark1_ff) phase_in = PH_MARK2;
            end
            PH_MARK2: begin
               phase_in = (rx == mark2_ff) ? PH_BODY : PH_HUNT;
            end
            PH_BODY: begin
               if (rx == mark1_ff) phase_in = PH_BODY_MARK;
            end
            PH_BODY_MARK: begin
               phase_in = PH_BODY;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // Queue work and update the frame state
   always_comb begin
      push     = 1'b0;
      cmd      = '0;
      cmd.op   = OP_BYTE1;
      cmd.pos  = POS_W'(count_ff);
      count_in = count_ff;
      sum_in   = sum_ff;
      last_in  = last_ff;
      size_in  = size_ff;
      addr_in  = addr_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         case (phase_ff)
            PH_BODY: begin
               if (rx != mark1_ff) begin
                  if (room1) begin
                     push       = 1'b1;
                     cmd.byte_a = rx;
                     count_in   = count_ff + CW'(1);
                     sum_in     = sum_ff + rx;
                     last_in    = rx;
                     if (count_ff == CW'(0)) size_in = rx;
                     if (count_ff == CW'(1)) addr_in = rx;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            PH_BODY_MARK: begin
               if (rx == mark2_ff) begin
                  // Closing mark: hand the frame to the back, start a new one
                  push                   = 1'b1;
                  cmd.op                 = OP_VERDICT;
                  cmd.pos                = '0;
                  cmd.verdict.overflowed = ovf_ff;
                  cmd.verdict.empty      = (count_ff == CW'(0));
                  cmd.verdict.short_body = (count_ff < CW'(2));
                  cmd.verdict.sum        = sum_ff;
                  cmd.verdict.last       = last_ff;
                  cmd.verdict.size       = size_ff;
                  cmd.verdict.addr       = addr_ff;
                  count_in               = '0;
                  sum_in                 = '0;
                  last_in                = '0;
                  size_in                = '0;
                  addr_in                = '0;
                  ovf_in                 = 1'b0;
               end else if (room1) begin
                  // Lone first mark byte stands for itself
                  push       = 1'b1;
                  cmd.byte_a = mark1_ff;
                  cmd.byte_b = rx;
                  if (count_ff == CW'(0)) size_in = mark1_ff;
                  if (count_ff == CW'(1)) addr_in = mark1_ff;
                  if (room2) begin
                     cmd.op   = OP_BYTE2;
                     count_in = count_ff + CW'(2);
                     sum_in   = sum_ff + mark1_ff + rx;
                     last_in  = rx;
                     if (count_ff == CW'(0)) addr_in = rx;
                  end else begin
                     count_in = count_ff + CW'(1);
                     sum_in   = sum_ff + mark1_ff;
                     last_in  = mark1_ff;
                     ovf_in   = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         sum_ff   <= '0;
         last_ff  <= '0;
         size_ff  <= '0;
         addr_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         last_ff  <= last_in;
         size_ff  <= size_in;
         addr_ff  <= addr_in;
         ovf_ff   <= ovf_in;
      end
   end

   `SFLD_ASSERT_NEXT(a_mark_in_body_returns, clock, reset, body_mark_take, phase_ff == PH_BODY)
   `SFLD_ASSERT_IMPLY(a_count_bounded, clock, reset, 1'b1, count_ff <= CW'(MAX_BODY))

endmodule

@@ src/sfld_queue.sv @@
// -----------------------------------------------------------------------------
// sfld_queue
// Short FIFO of queued work between the front and the back.
// -----------------------------------------------------------------------------
`include "sync_framed_lrc_deframer_macros.svh"

module sfld_queue import sfld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output queue_status_type status,
   output cmd_type          head
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count_ff, count_in;

   assign status.full  = (count_ff == (AW + 1)'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + (AW + 1)'(1);
      if (pop && !push) count_in = count_ff - (AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed work
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SFLD_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, count_ff < (AW + 1)'(QUEUE_DEPTH))
   `SFLD_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, pop, count_ff != '0)

endmodule

@@ src/sfld_back.sv @@
// -----------------------------------------------------------------------------
// sfld_back
// Turns queued work into result items: body bytes and frame verdicts.
// -----------------------------------------------------------------------------
`include "sync_framed_lrc_deframer_macros.svh"

module sfld_back import sfld_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  cmd_type          head,
   output logic             pop,
   sfld_rsp_if.source       rsp
);

   logic              out_valid_ff, out_valid_in;
   result_type        res_ff, res_in;
   logic              pend_ff, pend_in;
   logic [BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic [POS_W-1:0]  pend_pos_ff, pend_pos_in;
   logic              load;
   result_type        verdict_res;

   assign load = !out_valid_ff || rsp.ready;

   // Check the LRC and classify the frame
   always_comb begin
      logic [BYTE_W-1:0] prior;
      logic [BYTE_W-1:0] expect_sum;
      logic [BYTE_W-1:0] chan;
      prior       = head.verdict.sum - head.verdict.last;
      expect_sum  = 8'd0 - prior;
      chan        = head.verdict.addr - CHANNEL_BASE;
      verdict_res = '0;
      verdict_res.item_kind   = KIND_VERDICT;
      verdict_res.last_of_run = 1'b1;
      if (head.verdict.overflowed) begin
         verdict_res.frame_status = ST_OVERFLOW;
      end else if (head.verdict.empty || (expect_sum != head.verdict.last)) begin
         verdict_res.frame_status = ST_BAD_SUM;
      end else begin
         case (head.verdict.size)
            SIZE_ULTRA: begin
               if (head.verdict.short_body || (chan >= CHANNELS)) begin
                  verdict_res.frame_status = ST_BAD_CHANNEL;
               end else begin
                  verdict_res.sensor_kind    = SK_ULTRA;
                  verdict_res.sensor_channel = chan[CHAN_W-1:0];
               end
            end
            SIZE_PROP: verdict_res.sensor_kind = SK_PROP;
            SIZE_IMU:  verdict_res.sensor_kind = SK_IMU;
            SIZE_GPS:  verdict_res.sensor_kind = SK_GPS;
            default:   verdict_res.frame_status = ST_UNKNOWN;
         endcase
      end
   end

   // Load the output register from the held second byte or the queue head
   always_comb begin
      out_valid_in = out_valid_ff;
      res_in       = res_ff;
      pend_in      = pend_ff;
      pend_byte_in = pend_byte_ff;
      pend_pos_in  = pend_pos_ff;
      pop          = 1'b0;
      if (load) begin
         out_valid_in = pend_ff || q_status.valid;
         if (pend_ff) begin
            res_in               = '0;
            res_in.item_kind     = KIND_BODY;
            res_in.body_byte     = pend_byte_ff;
            res_in.byte_position = pend_pos_ff;
            res_in.last_of_run   = 1'b1;
            pend_in              = 1'b0;
         end else if (q_status.valid) begin
            pop = 1'b1;
            case (head.op)
               OP_BYTE1: begin
                  res_in               = '0;
                  res_in.item_kind     = KIND_BODY;
                  res_in.body_byte     = head.byte_a;
                  res_in.byte_position = head.pos;
                  res_in.last_of_run   = 1'b1;
               end
               OP_BYTE2: begin
                  res_in               = '0;
                  res_in.item_kind     = KIND_BODY;
                  res_in.body_byte     = head.byte_a;
                  res_in.byte_position = head.pos;
                  res_in.last_of_run   = 1'b0;
                  pend_in              = 1'b1;
                  pend_byte_in         = head.byte_b;
                  pend_pos_in          = head.pos + POS_W'(1);
               end
               default: begin
                  res_in = verdict_res;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      res_ff       <= res_in;
      pend_byte_ff <= pend_byte_in;
      pend_pos_ff  <= pend_pos_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.item_kind      = res_ff.item_kind;
   assign rsp.body_byte      = res_ff.body_byte;
   assign rsp.byte_position  = res_ff.byte_position;
   assign rsp.frame_status   = res_ff.frame_status;
   assign rsp.sensor_kind    = res_ff.sensor_kind;
   assign rsp.sensor_channel = res_ff.sensor_channel;
   assign rsp.last_of_run    = res_ff.last_of_run;

   `SFLD_ASSERT_IMPLY(a_pending_has_first, clock, reset, pend_ff, out_valid_ff && !res_ff.last_of_run)
   `SFLD_ASSERT_IMPLY(a_no_pop_while_pending, clock, reset, pend_ff, !pop)

endmodule

@@ tb/sv/sync_framed_lrc_deframer_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// sync_framed_lrc_deframer_tb
// Self-checking bench for the framed LRC deframer.
// -----------------------------------------------------------------------------
// Feeds received bytes through req_ch, both well-formed frames with random
// content and loose noise, under several mark settings written through csr_ch.
// A cycle-free model of the deframer tracks every accepted byte and queues the
// body bytes and verdicts it should produce; each result taken from rsp_ch is
// compared field by field with the oldest queued one. Both channels stall in
// short random bursts except in the final stretch of traffic.
// -----------------------------------------------------------------------------
module sync_framed_lrc_deframer_tb import sfld_pkg::*; ();

   localparam int MAX_BODY = 128;

   // Register indexes that the block does not implement
   localparam logic [CSR_IDX_W-1:0] REG_BEYOND = REG_MARK_SECOND + 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_TOP    = '1;

   logic clock = 1'b0;
   logic reset;

   sfld_req_if req_ch ();
   sfld_rsp_if rsp_ch ();
   sfld_csr_if csr_ch ();

   sync_framed_lrc_deframer #(
      .MAX_BODY (MAX_BODY)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Deframer model state and mark registers
   logic [BYTE_W-1:0] cfg_mark_first;
   logic [BYTE_W-1:0] cfg_mark_second;
   phase_type         hunt_ph;
   logic [BYTE_W-1:0] stored_count;
   logic [BYTE_W-1:0] body_sum;
   logic [BYTE_W-1:0] last_stored;
   logic [BYTE_W-1:0] size_seen;
   logic [BYTE_W-1:0] addr_seen;
   logic              dropped_byte;

   result_type        step_results[2];
   int                step_count;
   result_type        frame_results_due[$];

   logic [BYTE_W-1:0] frame_body[$];

   bit gaps_on = 1'b1;
   int stall_left = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int verdicts_by_status[8];

   // ---------------------------------------------------------------------------
   // Model of the deframer
   // ---------------------------------------------------------------------------
   function automatic void clear_frame_state();
      stored_count = '0;
      body_sum     = '0;
      last_stored  = '0;
      size_seen    = '0;
      addr_seen    = '0;
      dropped_byte = 1'b0;
   endfunction

   // Store one body byte, or note the drop once the buffer is full
   function automatic void store_body_byte(input logic [BYTE_W-1:0] b);
      result_type r;
      if (stored_count >= MAX_BODY) begin
         dropped_byte = 1'b1;
      end else begin
         if (stored_count == 0) size_seen = b;
         if (stored_count == 1) addr_seen = b;
         body_sum    = body_sum + b;
         last_stored = b;
         r = '0;
         r.item_kind     = KIND_BODY;
         r.body_byte     = b;
         r.byte_position = stored_count[POS_W-1:0];
         step_results[step_count] = r;
         step_count++;
         stored_count = stored_count + 1'b1;
      end
   endfunction

   // Classify the finished frame, then start a fresh one
   function automatic void judge_frame();
      result_type        r;
      logic [BYTE_W-1:0] chan_off;
      r = '0;
      r.item_kind    = KIND_VERDICT;
      r.frame_status = ST_OK;
      r.sensor_kind  = SK_ULTRA;
      if (dropped_byte) begin
         r.frame_status = ST_OVERFLOW;
      end else if (stored_count == 0) begin
         r.frame_status = ST_BAD_SUM;
      end else if (body_sum != '0) begin
         // the last byte cancels the sum of the others exactly when all sum to 0
         r.frame_status = ST_BAD_SUM;
      end else if (size_seen == SIZE_ULTRA) begin
         chan_off = addr_seen - CHANNEL_BASE;
         if (stored_count < 2 || chan_off >= CHANNELS)
            r.frame_status = ST_BAD_CHANNEL;
         else
            r.sensor_channel = chan_off[CHAN_W-1:0];
      end else if (size_seen == SIZE_PROP) begin
         r.sensor_kind = SK_PROP;
      end else if (size_seen == SIZE_IMU) begin
         r.sensor_kind = SK_IMU;
      end else if (size_seen == SIZE_GPS) begin
         r.sensor_kind = SK_GPS;
      end else begin
         r.frame_status = ST_UNKNOWN;
      end
      step_results[step_count] = r;
      step_count++;
      clear_frame_state();
   endfunction

   // Advance the model by one received byte and queue what it yields
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
      int i;
      step_count = 0;
      case (hunt_ph)
         PH_HUNT: begin
            if (b == cfg_mark_first) hunt_ph = PH_MARK2;
         end
         PH_MARK2: begin
            hunt_ph = (b == cfg_mark_second) ? PH_BODY : PH_HUNT;
         end
         PH_BODY: begin
            if (b == cfg_mark_first) hunt_ph = PH_BODY_MARK;
            else store_body_byte(b);
         end
         default: begin
            if (b == cfg_mark_second) begin
               judge_frame();
            end else begin
               store_body_byte(cfg_mark_first);
               store_body_byte(b);
            end
            hunt_ph = PH_BODY;
         end
      endcase
      for (i = 0; i < step_count; i++) begin
         step_results[i].last_of_run = (i == step_count - 1);
         frame_results_due.push_back(step_results[i]);
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------
   function automatic void report_result(input string what, input result_type want,
                                         input result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t ns %s: expected kind %0d byte %02h pos %0d status %0d sensor %0d",
                  $time, what, want.item_kind, want.body_byte, want.byte_position,
                  want.frame_status, want.sensor_kind);
         $display("   chan %0d last %0d; got kind %0d byte %02h pos %0d status %0d",
                  want.sensor_channel, want.last_of_run, got.item_kind, got.body_byte,
                  got.byte_position, got.frame_status);
         $display("   sensor %0d chan %0d last %0d",
                  got.sensor_kind, got.sensor_channel, got.last_of_run);
      end
   endfunction

   // Check results, track register writes and model accepted requests
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      if (reset) begin
         cfg_mark_first  = MARK_FIRST_RST;
         cfg_mark_second = MARK_SECOND_RST;
         hunt_ph         = PH_HUNT;
         clear_frame_state();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.item_kind      = rsp_ch.item_kind;
            got.body_byte      = rsp_ch.body_byte;
            got.byte_position  = rsp_ch.byte_position;
            got.frame_status   = rsp_ch.frame_status;
            got.sensor_kind    = rsp_ch.sensor_kind;
            got.sensor_channel = rsp_ch.sensor_channel;
            got.last_of_run    = rsp_ch.last_of_run;
            results_checked++;
            if (frame_results_due.size() == 0) begin
               report_result("result with nothing pending", '0, got);
            end else begin
               want = frame_results_due.pop_front();
               if (got.item_kind !== want.item_kind || got.body_byte !== want.body_byte ||
                   got.byte_position !== want.byte_position ||
                   got.frame_status !== want.frame_status ||
                   got.sensor_kind !== want.sensor_kind ||
                   got.sensor_channel !== want.sensor_channel ||
                   got.last_of_run !== want.last_of_run)
                  report_result("result mismatch", want, got);
               if (want.item_kind == KIND_VERDICT)
                  verdicts_by_status[want.frame_status]++;
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               REG_MARK_FIRST:  cfg_mark_first  = csr_ch.wdata;
               REG_MARK_SECOND: cfg_mark_second = csr_ch.wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            deframe_byte(req_ch.rx_byte);
      end
   end

   // Stall the result channel in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers; every task starts and ends at a falling edge
   // ---------------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Hold the request channel idle until every pending result is out
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (frame_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_marks(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
      drain();
      write_reg(REG_MARK_FIRST, first);
      write_reg(REG_MARK_SECOND, second);
      csr_ch.valid <= 1'b0;
   endtask

   // Drive the deframer into an empty body, whatever phase it is in
   task automatic open_frame();
      while (!(hunt_ph == PH_BODY && stored_count == 0 && !dropped_byte)) begin
         case (hunt_ph)
            PH_HUNT, PH_BODY: send_byte(cfg_mark_first);
            default:          send_byte(cfg_mark_second);
         endcase
      end
   endtask

   // Send frame_body as one frame and close it with the mark
   task automatic send_body();
      int i;
      open_frame();
      for (i = 0; i < frame_body.size(); i++) send_byte(frame_body[i]);
      send_byte(cfg_mark_first);
      send_byte(cfg_mark_second);
   endtask

   // Make the last body byte the LRC of the ones before it
   function automatic void fix_lrc();
      logic [BYTE_W-1:0] total;
      int i;
      total = '0;
      for (i = 0; i + 1 < frame_body.size(); i++) total = total + frame_body[i];
      if (frame_body.size() != 0) frame_body[frame_body.size() - 1] = 8'd0 - total;
   endfunction

   // Build a random body that the current marks cannot split or close early
   function automatic void compose_body(input logic [BYTE_W-1:0] size_code, input int len,
                                        input bit corrupt);
      logic [BYTE_W-1:0] val;
      int                i;
      int                tries;
      int                at;
      bit                clean;
      tries = 0;
      clean = 1'b0;
      while (!clean && tries < 16) begin
         frame_body.delete();
         for (i = 0; i < len; i++) begin
            val = BYTE_W'($urandom);
            frame_body.push_back(val);
         end
         if (len > 0) frame_body[0] = size_code;
         if (len > 2 && size_code == SIZE_ULTRA && $urandom_range(0, 3) != 0) begin
            val = BYTE_W'($urandom_range(0, 7));
            frame_body[1] = CHANNEL_BASE + val;
         end
         // plant a lone first-mark byte inside the body now and then
         if (len > 3 && $urandom_range(0, 2) == 0) begin
            at = $urandom_range(1, len - 3);
            frame_body[at] = cfg_mark_first;
         end
         fix_lrc();
         if (corrupt && len > 0) begin
            val = BYTE_W'($urandom_range(1, 255));
            frame_body[len - 1] = frame_body[len - 1] ^ val;
         end
         clean = 1'b1;
         for (i = 0; i < len; i++)
            if (frame_body[i] == cfg_mark_first &&
                (i == len - 1 || frame_body[i + 1] == cfg_mark_first ||
                 frame_body[i + 1] == cfg_mark_second))
               clean = 1'b0;
         tries++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Noise while hunting, broken opening marks, then a clean open
   task automatic test_mark_hunt();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfg_mark_second);
      send_byte(cfg_mark_first);
      send_byte(8'h00);
      send_byte(cfg_mark_first);
      send_byte(cfg_mark_first);
      send_byte(cfg_mark_first);
      send_byte(cfg_mark_second);
   endtask

   // One short frame per verdict and sensor kind
   task automatic test_frame_verdicts();
      frame_body.delete();
      send_body();
      frame_body = '{SIZE_PROP, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_IMU, 8'hFF, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_GPS, 8'h80, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_ULTRA, CHANNEL_BASE, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_ULTRA, CHANNEL_BASE + 8'd6, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_ULTRA, CHANNEL_BASE + CHANNELS, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{SIZE_ULTRA, 8'h00};
      fix_lrc();
      send_body();
      frame_body = '{8'h00};
      send_body();
      frame_body = '{8'hFF, 8'h01};
      send_body();
      frame_body = '{SIZE_PROP, 8'h03, 8'h07};
      send_body();
      frame_body = '{SIZE_PROP, cfg_mark_first, 8'h00, 8'h00};
      fix_lrc();
      send_body();
   endtask

   // Fill the buffer exactly, then overrun it, then recover
   task automatic test_buffer_limits();
      compose_body(SIZE_GPS, MAX_BODY, 1'b0);
      send_body();
      compose_body(SIZE_IMU, MAX_BODY + 1, 1'b0);
      send_body();
      compose_body(SIZE_PROP, MAX_BODY + 3, 1'b1);
      send_body();
      compose_body(SIZE_ULTRA, 4, 1'b0);
      send_body();
   endtask

   // Writes to unimplemented registers leave the marks alone
   task automatic test_register_access();
      logic [BYTE_W-1:0] val;
      drain();
      val = BYTE_W'($urandom);
      write_reg(REG_BEYOND, val);
      val = BYTE_W'($urandom);
      write_reg(REG_TOP, val);
      csr_ch.valid <= 1'b0;
      compose_body(SIZE_PROP, 5, 1'b0);
      send_body();
   endtask

   // Random frames and noise under a series of mark settings
   task automatic test_random_traffic();
      logic [BYTE_W-1:0] size_code;
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] second;
      int                seg;
      int                seg_end;
      int                len;
      int                pick;
      int                rounds;
      int                n;
      for (seg = 0; seg < 6; seg++) begin
         case (seg)
            0: begin first = MARK_FIRST_RST; second = MARK_SECOND_RST; end
            1: begin first = 8'h00;          second = 8'hFF;           end
            2: begin first = 8'hFF;          second = 8'h00;           end
            3: begin first = 8'hFF;          second = 8'hFF;           end
            4: begin first = SIZE_ULTRA;     second = SIZE_PROP;       end
            default: begin
               first  = BYTE_W'($urandom);
               second = BYTE_W'($urandom);
            end
         endcase
         set_marks(first, second);
         seg_end = bytes_sent + 180;
         rounds  = 0;
         while (bytes_sent < seg_end) begin
            // switch gaps on and off in stretches; none in the final stretch
            if (rounds % 8 == 0) gaps_on = (seg != 5) && ($urandom_range(0, 3) != 0);
            rounds++;
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
               n = $urandom_range(1, 6);
               repeat (n) send_byte(BYTE_W'($urandom));
            end else if (pick == 1) begin
               send_byte(cfg_mark_first);
               if ($urandom_range(0, 1) == 0) send_byte(cfg_mark_first);
               else send_byte(BYTE_W'($urandom));
            end else begin
               case ($urandom_range(0, 5))
                  0, 4: size_code = SIZE_ULTRA;
                  1:    size_code = SIZE_PROP;
                  2:    size_code = SIZE_IMU;
                  3:    size_code = SIZE_GPS;
                  default: size_code = BYTE_W'($urandom);
               endcase
               n = $urandom_range(0, 59);
               if (n == 0) len = $urandom_range(MAX_BODY + 1, MAX_BODY + 6);
               else if (n < 6) len = $urandom_range(13, MAX_BODY);
               else len = $urandom_range(0, 12);
               compose_body(size_code, len, $urandom_range(0, 9) == 0);
               send_body();
            end
         end
      end
   endtask

   // Limit on the whole run
   initial begin
      #10_000_000;
      $display("run stopped by timeout, %0d results still pending",
               frame_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.wdata     = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      test_mark_hunt();
      test_frame_verdicts();
      test_buffer_limits();
      test_register_access();
      test_random_traffic();

      drain();
      mismatches += frame_results_due.size();
      $display("%0d bytes sent under 6 mark settings, %0d results checked",
               bytes_sent, results_checked);
      $display("verdicts: ok %0d, bad sum %0d, unknown size %0d, overflow %0d, bad channel %0d",
               verdicts_by_status[ST_OK], verdicts_by_status[ST_BAD_SUM],
               verdicts_by_status[ST_UNKNOWN], verdicts_by_status[ST_OVERFLOW],
               verdicts_by_status[ST_BAD_CHANNEL]);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ sync_framed_lrc_deframer.f @@
+incdir+src
src/sfld_pkg.sv
src/sfld_if.sv
src/sfld_front.sv
src/sfld_queue.sv
src/sfld_back.sv
src/sync_framed_lrc_deframer.sv
tb/sv/sync_framed_lrc_deframer_tb.sv
